// File: design/trc_pkg.sv
`timescale 1ns / 1ps

package trc_pkg;

  localparam int unsigned CfgW         = 7;
  localparam int unsigned VW           = 16;
  localparam int unsigned CW           = 24;
  localparam int unsigned DW           = 25;
  localparam int unsigned PW           = 50;
  localparam int unsigned YBW          = 36;
  localparam int unsigned BoxW         = 10;
  localparam int unsigned TW           = 64;
  localparam int unsigned MaskW        = 64;
  localparam int unsigned RowW         = 6;
  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned DefMaxWidth  = 64;
  localparam int unsigned DefMaxHeight = 64;

  localparam logic [CfgW-1:0] ResetFrameWidth  = 7'd64;
  localparam logic [CfgW-1:0] ResetFrameHeight = 7'd32;

  // Offset that moves Q2.14 coordinates from [-1, 1] to [0, 2].
  localparam logic signed [VW:0] NdcOffset = 17'sd16384;
  // Weights are compared against -1/100, so edge values are scaled by this.
  localparam logic signed [TW-1:0] WeightScale = 64'sd100;
  localparam int unsigned SubPixBits = 15;

  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH,
    CFG_FRAME_HEIGHT
  } cfg_idx_e;

  typedef struct packed {
    logic signed [VW-1:0] vertex0_x;
    logic signed [VW-1:0] vertex0_y;
    logic signed [VW-1:0] vertex1_x;
    logic signed [VW-1:0] vertex1_y;
    logic signed [VW-1:0] vertex2_x;
    logic signed [VW-1:0] vertex2_y;
  } tri_in_t;

  typedef struct packed {
    logic [RowW-1:0]  row_index;
    logic [MaskW-1:0] coverage_mask;
    logic             last_row;
  } row_out_t;

  // One set-up triangle handed from the front to the back. The t values are
  // 100 * edge + area at pixel (0, ymin); dx and dy step them by one pixel.
  typedef struct packed {
    logic                 empty;
    logic                 zero_area;
    logic                 area_neg;
    logic [RowW-1:0]      xmin;
    logic [RowW-1:0]      xmax;
    logic [RowW-1:0]      ymin;
    logic [RowW-1:0]      ymax;
    logic [2:0][TW-1:0]   t;
    logic [2:0][TW-1:0]   dx;
    logic [2:0][TW-1:0]   dy;
  } job_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MAP,
    F_BOX,
    F_MUL,
    F_SUM,
    F_EDGE,
    F_SCALE,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_LOAD,
    B_ROW,
    B_EMPTY
  } back_state_e;

endpackage

// File: design/trc_front.sv
`timescale 1ns / 1ps

module trc_front #(
  parameter int unsigned MaxWidth  = trc_pkg::DefMaxWidth,
  parameter int unsigned MaxHeight = trc_pkg::DefMaxHeight
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  trc_pkg::tri_in_t          in_data_i,
  input  logic [trc_pkg::CfgW-1:0]  frame_width_i,
  input  logic [trc_pkg::CfgW-1:0]  frame_height_i,
  output logic                      push_o,
  input  logic                      full_i,
  output trc_pkg::job_t             job_o
);
  import trc_pkg::*;

  front_state_e state_q, state_d;

  logic [CfgW-1:0] w_eff, h_eff;
  tri_in_t         in_q;
  logic [CfgW-1:0] w_q, h_q;

  logic signed [VW-1:0] vxi [3];
  logic signed [VW-1:0] vyi [3];
  logic signed [VW:0]   sx  [3];
  logic signed [VW:0]   sy  [3];
  logic signed [CW-1:0] vx_d [3];
  logic signed [CW-1:0] vy_d [3];
  logic signed [CW-1:0] vx_q [3];
  logic signed [CW-1:0] vy_q [3];

  logic signed [CW-1:0]   mnx, mxx, mny, mxy;
  logic signed [BoxW-1:0] trx, try_, limx, limy;
  logic signed [BoxW-1:0] xmin_d, xmax_d, ymin_d, ymax_d;
  logic signed [BoxW-1:0] xmin_q, xmax_q, ymin_q, ymax_q;
  logic signed [DW-1:0]   a_d [3];
  logic signed [DW-1:0]   b_d [3];
  logic signed [DW-1:0]   a_q [3];
  logic signed [DW-1:0]   b_q [3];

  logic                 empty_q;
  logic signed [PW-1:0] pa_q, pb_q, pc_q, pd_q, pe_q, pf_q;
  logic signed [YBW-1:0] yb_q [3];

  logic signed [TW-1:0] area_q;
  logic signed [TW-1:0] c_q [3];
  logic signed [TW-1:0] e_q [3];
  job_t                 job_q;

  // Frame sizes of zero act as one, and sizes above the maximum saturate.
  always_comb begin
    w_eff = frame_width_i;
    if (w_eff == '0) begin
      w_eff = CfgW'(1);
    end else if (w_eff > CfgW'(MaxWidth)) begin
      w_eff = CfgW'(MaxWidth);
    end
    h_eff = frame_height_i;
    if (h_eff == '0) begin
      h_eff = CfgW'(1);
    end else if (h_eff > CfgW'(MaxHeight)) begin
      h_eff = CfgW'(MaxHeight);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE:  if (in_valid_i) state_d = F_MAP;
      F_MAP:   state_d = F_BOX;
      F_BOX:   state_d = F_MUL;
      F_MUL:   state_d = F_SUM;
      F_SUM:   state_d = F_EDGE;
      F_EDGE:  state_d = F_SCALE;
      F_SCALE: state_d = F_PUSH;
      F_PUSH:  if (!full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == F_IDLE);
    push_o     = (state_q == F_PUSH) && !full_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
      w_q  <= w_eff;
      h_q  <= h_eff;
    end
  end

  // Screen mapping in units of 2^-15 pixel, y flipped.
  always_comb begin
    vxi[0] = in_q.vertex0_x;
    vxi[1] = in_q.vertex1_x;
    vxi[2] = in_q.vertex2_x;
    vyi[0] = in_q.vertex0_y;
    vyi[1] = in_q.vertex1_y;
    vyi[2] = in_q.vertex2_y;
    for (int k = 0; k < 3; k++) begin
      sx[k]   = $signed({vxi[k][VW-1], vxi[k]}) + NdcOffset;
      sy[k]   = NdcOffset - $signed({vyi[k][VW-1], vyi[k]});
      vx_d[k] = $signed({1'b0, w_q}) * sx[k];
      vy_d[k] = $signed({1'b0, h_q}) * sy[k];
    end
  end

  // Bounding box: floor of the minimum clamped at zero, and the maximum
  // rounded toward zero and clamped to the last column or row.
  always_comb begin
    mnx = vx_q[0];
    mxx = vx_q[0];
    mny = vy_q[0];
    mxy = vy_q[0];
    for (int k = 1; k < 3; k++) begin
      if (vx_q[k] < mnx) mnx = vx_q[k];
      if (vx_q[k] > mxx) mxx = vx_q[k];
      if (vy_q[k] < mny) mny = vy_q[k];
      if (vy_q[k] > mxy) mxy = vy_q[k];
    end
    xmin_d = (mnx <= 0) ? '0 : BoxW'(mnx >>> SubPixBits);
    ymin_d = (mny <= 0) ? '0 : BoxW'(mny >>> SubPixBits);
    trx  = (mxx >= 0) ? BoxW'(mxx >>> SubPixBits) : -BoxW'((-mxx) >>> SubPixBits);
    try_ = (mxy >= 0) ? BoxW'(mxy >>> SubPixBits) : -BoxW'((-mxy) >>> SubPixBits);
    limx = $signed({{(BoxW-CfgW){1'b0}}, w_q}) - BoxW'(1);
    limy = $signed({{(BoxW-CfgW){1'b0}}, h_q}) - BoxW'(1);
    xmax_d = (trx > limx) ? limx : trx;
    ymax_d = (try_ > limy) ? limy : try_;
    a_d[0] = vy_q[2] - vy_q[1];
    b_d[0] = vx_q[2] - vx_q[1];
    a_d[1] = vy_q[0] - vy_q[2];
    b_d[1] = vx_q[0] - vx_q[2];
    a_d[2] = vy_q[1] - vy_q[0];
    b_d[2] = vx_q[1] - vx_q[0];
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      vx_q[k] <= vx_d[k];
      vy_q[k] <= vy_d[k];
      a_q[k]  <= a_d[k];
      b_q[k]  <= b_d[k];
      yb_q[k] <= ymin_q * b_q[k];
      e_q[k]  <= c_q[k] - (TW'(yb_q[k]) <<< SubPixBits);
    end
    xmin_q <= xmin_d;
    xmax_q <= xmax_d;
    ymin_q <= ymin_d;
    ymax_q <= ymax_d;

    empty_q <= (xmin_q > xmax_q) || (ymin_q > ymax_q);
    pa_q <= a_q[0] * b_q[1];
    pb_q <= b_q[0] * a_q[1];
    pc_q <= vx_q[1] * a_q[0];
    pd_q <= vy_q[1] * b_q[0];
    pe_q <= vx_q[2] * a_q[1];
    pf_q <= vy_q[2] * b_q[1];

    area_q <= TW'(pa_q) - TW'(pb_q);
    c_q[0] <= TW'(pd_q) - TW'(pc_q);
    c_q[1] <= TW'(pf_q) - TW'(pe_q);
    c_q[2] <= TW'(pa_q) - TW'(pb_q) - TW'(pd_q) + TW'(pc_q) - TW'(pf_q) + TW'(pe_q);

    job_q.empty     <= empty_q;
    job_q.zero_area <= (area_q == '0);
    job_q.area_neg  <= area_q[TW-1];
    job_q.xmin      <= xmin_q[RowW-1:0];
    job_q.xmax      <= xmax_q[RowW-1:0];
    job_q.ymin      <= ymin_q[RowW-1:0];
    job_q.ymax      <= ymax_q[RowW-1:0];
    for (int k = 0; k < 3; k++) begin
      job_q.t[k]  <= e_q[k] * WeightScale + area_q;
      job_q.dx[k] <= (TW'(a_q[k]) * WeightScale) <<< SubPixBits;
      job_q.dy[k] <= -((TW'(b_q[k]) * WeightScale) <<< SubPixBits);
    end
  end

  assign job_o = job_q;

endmodule

// File: design/trc_queue.sv
`timescale 1ns / 1ps

module trc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  trc_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          nonempty_o,
  output trc_pkg::job_t job_o
);
  import trc_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  job_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o     = (cnt_q == CntW'(QueueDepth));
  assign nonempty_o = (cnt_q != '0);
  assign job_o      = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + PtrW'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + PtrW'(1);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= job_i;
  end

endmodule

// File: design/trc_back.sv
`timescale 1ns / 1ps

module trc_back #(
  parameter int unsigned MaxWidth = trc_pkg::DefMaxWidth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              nonempty_i,
  input  trc_pkg::job_t     job_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output trc_pkg::row_out_t out_data_o
);
  import trc_pkg::*;

  back_state_e state_q, state_d;
  job_t        cur_q;
  logic [RowW-1:0] row_q;
  logic signed [TW-1:0] lane_q [3][MaxWidth];
  logic [MaskW-1:0] mask;
  logic [2:0]       below;
  logic             slot_free, emit, last;
  logic             out_valid_q;
  row_out_t         out_q;

  assign slot_free = !out_valid_q || out_ready_i;
  assign last      = (row_q == cur_q.ymax);

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE:  if (nonempty_i) state_d = job_i.empty ? B_EMPTY : B_LOAD;
      B_LOAD:  state_d = B_ROW;
      B_ROW:   if (emit && last) state_d = B_IDLE;
      B_EMPTY: if (emit) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    pop_o = (state_q == B_IDLE) && nonempty_i;
    emit  = ((state_q == B_ROW) || (state_q == B_EMPTY)) && slot_free;
  end

  // A pixel is covered when all three weights fall on the same side of -0.01.
  always_comb begin
    mask  = '0;
    below = '0;
    for (int x = 0; x < MaxWidth; x++) begin
      for (int k = 0; k < 3; k++) begin
        below[k] = cur_q.area_neg ? (!lane_q[k][x][TW-1] && (lane_q[k][x] != '0))
                                  : lane_q[k][x][TW-1];
      end
      mask[x] = !cur_q.zero_area
             && (RowW'(x) >= cur_q.xmin) && (RowW'(x) <= cur_q.xmax)
             && (below[0] == below[1]) && (below[0] == below[2]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= job_i;
      row_q <= job_i.ymin;
    end
    if (state_q == B_LOAD) begin
      for (int k = 0; k < 3; k++) begin
        for (int x = 0; x < MaxWidth; x++) begin
          lane_q[k][x] <= $signed(cur_q.t[k]) + $signed(TW'(x)) * $signed(cur_q.dx[k]);
        end
      end
    end
    if (emit) begin
      if (state_q == B_EMPTY) begin
        out_q.row_index     <= '0;
        out_q.coverage_mask <= '0;
        out_q.last_row      <= 1'b1;
      end else begin
        out_q.row_index     <= row_q;
        out_q.coverage_mask <= mask;
        out_q.last_row      <= last;
        row_q               <= row_q + RowW'(1);
        for (int k = 0; k < 3; k++) begin
          for (int x = 0; x < MaxWidth; x++) begin
            lane_q[k][x] <= lane_q[k][x] + $signed(cur_q.dy[k]);
          end
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: design/triangle_row_coverage_top.sv
`timescale 1ns / 1ps
// Triangle row coverage.
// The input channel takes one triangle per beat: three vertices in Q2.14
// normalized coordinates. The output channel gives one beat per row of the
// triangle's clamped bounding box, top to bottom: the row index, a 64-bit
// coverage mask and a last-row flag. An empty box gives a single empty row
// marked last; a zero-area triangle gives all its rows with empty masks.
// The configuration port writes the frame width and height; both are taken
// when a triangle is accepted.
// Flow: the set-up front end steps through its map, box, multiply, sum, edge,
// scale and push states per triangle and accepts the next triangle as soon as
// its result moves into a two-entry queue. The row engine pops a triangle,
// loads its column lanes and then emits one row per cycle while the output
// register is free to take it.
// When the receiver stalls, the output register holds its row and the row
// engine waits; the front end keeps working until the queue is full.
// Reset returns the frame size to 64 by 32 and empties queue and output.
module triangle_row_coverage_top #(
  parameter int unsigned MaxWidth  = trc_pkg::DefMaxWidth,
  parameter int unsigned MaxHeight = trc_pkg::DefMaxHeight
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  trc_pkg::tri_in_t          in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output trc_pkg::row_out_t         out_data_o,
  input  logic                      cfg_we_i,
  input  trc_pkg::cfg_idx_e         cfg_idx_i,
  input  logic [trc_pkg::CfgW-1:0]  cfg_wdata_i
);
  import trc_pkg::*;

  logic [CfgW-1:0] frame_width_q, frame_height_q;
  logic            push, full, pop, nonempty;
  job_t            job_in, job_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= ResetFrameWidth;
      frame_height_q <= ResetFrameHeight;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata_i;
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  trc_front #(
    .MaxWidth  (MaxWidth),
    .MaxHeight (MaxHeight)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_data_i      (in_data_i),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .push_o         (push),
    .full_i         (full),
    .job_o          (job_in)
  );

  trc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .job_i      (job_in),
    .full_o     (full),
    .pop_i      (pop),
    .nonempty_o (nonempty),
    .job_o      (job_out)
  );

  trc_back #(
    .MaxWidth (MaxWidth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .nonempty_i  (nonempty),
    .job_i       (job_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: design/trc_checker.sv
`timescale 1ns / 1ps

module trc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input trc_pkg::row_out_t out_data_o
);
  import trc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("output beat changed while stalled");

  // Rows never go past the bottom row, so row 63 is always the last one.
  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last_row |-> out_data_o.row_index != 6'd63)
    else $error("non-final row at the bottom of the frame");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

endmodule

bind triangle_row_coverage_top trc_checker u_trc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// File: dv/tb_triangle_row_coverage_top.sv
`timescale 1ns / 1ps

module tb_triangle_row_coverage_top;
  import trc_pkg::*;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  tri_in_t          in_data;
  logic             out_valid;
  logic             out_ready;
  row_out_t         out_data;
  logic             cfg_we;
  cfg_idx_e         cfg_idx;
  logic [CfgW-1:0]  cfg_wdata;

  triangle_row_coverage_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  tri_in_t   tri_q[$];
  row_out_t  rows_expected[$];
  logic [CfgW-1:0] width_reg = 7'd64;
  logic [CfgW-1:0] height_reg = 7'd32;
  int        n_errors = 0;
  int        n_rows = 0;
  int        n_tris = 0;
  int        n_empty = 0;
  int        burst_left = 0;
  int        gap_left = 0;
  bit        hold_sender = 1'b0;
  int        stall_phase = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint clamp_size(logic [CfgW-1:0] v);
    longint s;
    s = longint'(v);
    if (s < 1) s = 1;
    if (s > 64) s = 64;
    return s;
  endfunction

  function automatic bit weight_below(longint e, longint a);
    longint t;
    t = 100 * e + a;
    return (a > 0) ? (t < 0) : (t > 0);
  endfunction

  // Screen coordinates are in 2^-15 pixel units; all edge math is exact.
  task automatic rasterize_rows(input tri_in_t t);
    longint w, h, area, xmin, xmax, ymin, ymax, mn, mx, py, px, e0, e1, e2;
    longint sx[3], sy[3];
    logic signed [15:0] rx[3], ry[3];
    logic [63:0] mask;
    row_out_t r;
    w = clamp_size(width_reg);
    h = clamp_size(height_reg);
    rx[0] = t.vertex0_x; ry[0] = t.vertex0_y;
    rx[1] = t.vertex1_x; ry[1] = t.vertex1_y;
    rx[2] = t.vertex2_x; ry[2] = t.vertex2_y;
    for (int i = 0; i < 3; i++) begin
      sx[i] = w * (longint'(rx[i]) + 16384);
      sy[i] = h * (16384 - longint'(ry[i]));
    end
    mn = sx[0]; mx = sx[0];
    for (int i = 1; i < 3; i++) begin
      if (sx[i] < mn) mn = sx[i];
      if (sx[i] > mx) mx = sx[i];
    end
    xmin = (mn <= 0) ? 0 : (mn >>> 15);
    xmax = (mx >= 0) ? (mx >>> 15) : -((-mx) >>> 15);
    mn = sy[0]; mx = sy[0];
    for (int i = 1; i < 3; i++) begin
      if (sy[i] < mn) mn = sy[i];
      if (sy[i] > mx) mx = sy[i];
    end
    ymin = (mn <= 0) ? 0 : (mn >>> 15);
    ymax = (mx >= 0) ? (mx >>> 15) : -((-mx) >>> 15);
    if (xmax > w - 1) xmax = w - 1;
    if (ymax > h - 1) ymax = h - 1;
    if (xmin > xmax || ymin > ymax) begin
      r.row_index = '0;
      r.coverage_mask = '0;
      r.last_row = 1'b1;
      rows_expected.push_back(r);
      n_empty++;
      return;
    end
    area = (sx[1] - sx[2]) * (sy[0] - sy[2]) - (sy[1] - sy[2]) * (sx[0] - sx[2]);
    for (longint y = ymin; y <= ymax; y++) begin
      mask = '0;
      py = y * 32768;
      if (area != 0) begin
        for (longint x = xmin; x <= xmax; x++) begin
          px = x * 32768;
          e0 = (px - sx[1]) * (sy[2] - sy[1]) - (py - sy[1]) * (sx[2] - sx[1]);
          e1 = (px - sx[2]) * (sy[0] - sy[2]) - (py - sy[2]) * (sx[0] - sx[2]);
          e2 = area - e0 - e1;
          if (weight_below(e0, area) == weight_below(e1, area) &&
              weight_below(e0, area) == weight_below(e2, area))
            mask[x[5:0]] = 1'b1;
        end
      end
      r.row_index = y[5:0];
      r.coverage_mask = mask;
      r.last_row = (y == ymax);
      rows_expected.push_back(r);
    end
  endtask

  function automatic tri_in_t make_tri(int a, int b, int c, int d, int e, int f);
    tri_in_t t;
    t.vertex0_x = a[15:0]; t.vertex0_y = b[15:0];
    t.vertex1_x = c[15:0]; t.vertex1_y = d[15:0];
    t.vertex2_x = e[15:0]; t.vertex2_y = f[15:0];
    return t;
  endfunction

  // Mostly on-screen triangles, with some anywhere in the full 16-bit range.
  function automatic tri_in_t random_tri();
    tri_in_t t;
    t[31:0] = $urandom;
    t[95:64] = $urandom;
    t[63:32] = $urandom;
    if ($urandom_range(0, 3) != 0) begin
      t.vertex0_x = 16'($signed($urandom_range(0, 36000)) - 18000);
      t.vertex0_y = 16'($signed($urandom_range(0, 36000)) - 18000);
      t.vertex1_x = 16'($signed($urandom_range(0, 36000)) - 18000);
      t.vertex1_y = 16'($signed($urandom_range(0, 36000)) - 18000);
      t.vertex2_x = 16'($signed($urandom_range(0, 36000)) - 18000);
      t.vertex2_y = 16'($signed($urandom_range(0, 36000)) - 18000);
    end
    return t;
  endfunction

  // Driver: bursts with random gaps; valid stays up until the beat is taken.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        rasterize_rows(in_data);
        n_tris++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (tri_q.size() > 0 && !hold_sender) begin
          in_valid <= 1'b1;
          in_data <= tri_q.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 8);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor with its own stall pattern: long open windows and short stalls.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_phase <= 0;
    end else begin
      if (out_valid && out_ready) begin
        n_rows++;
        if (rows_expected.size() == 0) begin
          $error("row beat with nothing expected: row %0d", out_data.row_index);
          n_errors++;
        end else begin
          row_out_t want;
          want = rows_expected.pop_front();
          if (want.row_index !== out_data.row_index) begin
            $error("row_index expected %0d actual %0d", want.row_index,
                   out_data.row_index);
            n_errors++;
          end
          if (want.coverage_mask !== out_data.coverage_mask) begin
            $error("coverage_mask expected %h actual %h", want.coverage_mask,
                   out_data.coverage_mask);
            n_errors++;
          end
          if (want.last_row !== out_data.last_row) begin
            $error("last_row expected %0d actual %0d", want.last_row,
                   out_data.last_row);
            n_errors++;
          end
        end
      end
      stall_phase <= (stall_phase + 1) % 97;
      if (stall_phase < 40) out_ready <= 1'b1;
      else if (stall_phase < 60) out_ready <= ($urandom_range(0, 3) != 0);
      else out_ready <= ($urandom_range(0, 2) == 0);
    end
  end

  task automatic wait_drained();
    while (tri_q.size() > 0 || in_valid || rows_expected.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_idx_e idx, logic [CfgW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_FRAME_WIDTH) width_reg = val;
    else height_reg = val;
  endtask

  initial begin
    logic [CfgW-1:0] sizes_w[5];
    logic [CfgW-1:0] sizes_h[5];
    sizes_w = '{7'd64, 7'd1, 7'd127, 7'd0, 7'd13};
    sizes_h = '{7'd64, 7'd0, 7'd1, 7'd100, 7'd9};
    // A clean falling edge makes sure every flop sees the reset.
    rst_n = 1'b1;
    cfg_we = 1'b0;
    cfg_idx = CFG_FRAME_WIDTH;
    cfg_wdata = '0;
    #1;
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset frame size first.
    tri_q.push_back(make_tri(-16384, 16383, 16383, 16383, 0, -16384));
    tri_q.push_back(make_tri(16383, 16383, -16384, 16383, 0, -16384));
    tri_q.push_back(make_tri(-32768, -32768, 32767, -32768, 0, 32767));
    tri_q.push_back(make_tri(32767, 32767, 32767, 32767, 32767, 32767));
    tri_q.push_back(make_tri(-32768, -32768, -32768, -32768, -32768, -32768));
    tri_q.push_back(make_tri(-16384, 0, 0, 0, 16383, 0));
    tri_q.push_back(make_tri(0, 0, 0, 0, 0, 0));
    tri_q.push_back(make_tri(-20000, 17000, -17000, 20000, -18000, 19000));
    tri_q.push_back(make_tri(-1000, 1000, 1000, 1000, 0, -1000));
    tri_q.push_back(make_tri(-16384, 16384, 16384, 16384, 16384, -16384));
    wait_drained();

    for (int p = 0; p < 5; p++) begin
      write_cfg(CFG_FRAME_WIDTH, sizes_w[p]);
      write_cfg(CFG_FRAME_HEIGHT, sizes_h[p]);
      tri_q.push_back(make_tri(-16384, 16383, 16383, 16383, 0, -16384));
      tri_q.push_back(make_tri(-32768, 32767, 32767, 32767, -32768, -32768));
      for (int i = 0; i < 20; i++) tri_q.push_back(random_tri());
      if (p == 2) begin
        // Hold the sender until the block has fully drained, then resume.
        while (tri_q.size() > 10 || in_valid) @(posedge clk);
        hold_sender = 1'b1;
        while (rows_expected.size() > 0 || in_valid) @(posedge clk);
        hold_sender = 1'b0;
      end
      wait_drained();
    end

    $display("Covered %0d triangles, %0d rows, %0d empty boxes over 6 frame sizes.",
             n_tris, n_rows, n_empty);
    if (n_errors == 0 && rows_expected.size() == 0) begin
      $display("** triangle_row_coverage_top: PASSED **");
    end else begin
      $display("** triangle_row_coverage_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("** triangle_row_coverage_top: FAILED **");
    $finish;
  end

endmodule

// File: sim.f
design/trc_pkg.sv
design/trc_front.sv
design/trc_queue.sv
design/trc_back.sv
design/triangle_row_coverage_top.sv
design/trc_checker.sv
dv/tb_triangle_row_coverage_top.sv
